/* hw/rtl/epc_pkg.sv */
package epc_pkg;

  localparam int unsigned DivW    = 32;
  localparam int unsigned RemW    = 17;
  localparam int unsigned DaysW   = 16;
  localparam int unsigned XW      = 25;
  localparam int unsigned LowW    = 7;
  localparam int unsigned RedW    = 10;
  localparam int unsigned RecipW  = 30;
  localparam int unsigned RecipSh = 32;

  // Each divisor is split into a power of two, taken off by a shift, and an odd part that is
  // divided by multiplying with its reciprocal scaled by two to the power 32.
  localparam logic [RedW-1:0]   DayOdd    = 10'd675;
  localparam logic [RecipW-1:0] DayRecip  = 30'd6362914;
  localparam logic [RedW-1:0]   HourOdd   = 10'd225;
  localparam logic [RecipW-1:0] HourRecip = 30'd19088743;
  localparam logic [RedW-1:0]   MinOdd    = 10'd15;
  localparam logic [RecipW-1:0] MinRecip  = 30'd286331153;
  localparam logic [RedW-1:0]   WdayOdd   = 10'd7;
  localparam logic [RecipW-1:0] WdayRecip = 30'd613566756;

  localparam logic [7:0] YearBase   = 8'd70;
  localparam logic [DaysW-1:0] WdayOffset = 16'd4;
  localparam logic [8:0] DaysLeap   = 9'd366;
  localparam logic [8:0] DaysCommon = 9'd365;
  localparam logic [8:0] LastFebDay = 9'd58;
  localparam logic [8:0] LeapDay    = 9'd59;
  localparam logic [3:0] MonthDec   = 4'd11;

  typedef enum logic [1:0] {
    DivDay,
    DivHour,
    DivMin,
    DivWday
  } div_op_e;

  typedef struct packed {
    logic    load;
    logic    div_go;
    div_op_e div_op;
    logic    div_take;
    logic    year_step;
    logic    leap_fix;
    logic    mon_step;
    logic    finish;
  } epc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic year_end;
    logic mon_end;
  } epc_status_t;

  // Years are held as an offset from 1900, which is itself a multiple of 100.
  function automatic logic is_leap(input logic [7:0] yr);
    is_leap = (yr[1:0] == 2'b00) && (yr != 8'd0) && (yr != 8'd200);
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] res;
    res = 9'd0;
    unique case (mon)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd59;
      4'd3:    res = 9'd90;
      4'd4:    res = 9'd120;
      4'd5:    res = 9'd151;
      4'd6:    res = 9'd181;
      4'd7:    res = 9'd212;
      4'd8:    res = 9'd243;
      4'd9:    res = 9'd273;
      4'd10:   res = 9'd304;
      4'd11:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/epc_div.sv */
module epc_div import epc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  div_op_e          op_i,
  input  logic [DivW-1:0]  dividend_i,
  output logic             done_o,
  output logic [DaysW-1:0] quo_o,
  output logic [RemW-1:0]  rem_o
);

  logic                 mul_q, mul_d;
  logic                 fix_q, fix_d;
  logic                 done_q, done_d;
  div_op_e              op_q, op_d;
  logic [XW-1:0]        x_q, x_d;
  logic [LowW-1:0]      low_q, low_d;
  logic [DaysW-1:0]     est_q, est_d;
  logic [DaysW-1:0]     quo_q, quo_d;
  logic [RemW-1:0]      rem_q, rem_d;
  logic [RecipW-1:0]    recip;
  logic [RedW-1:0]      dsr;
  logic [XW+RecipW-1:0] prod;
  logic [XW:0]          back;
  logic [XW:0]          diff;
  logic [RedW:0]        part;
  logic                 fits;
  logic [RedW-1:0]      red;

  // The estimate from the truncated reciprocal is at most one below the true quotient.
  always_comb begin
    recip = DayRecip;
    dsr   = DayOdd;
    unique case (op_q)
      DivDay: begin
        recip = DayRecip;
        dsr   = DayOdd;
      end
      DivHour: begin
        recip = HourRecip;
        dsr   = HourOdd;
      end
      DivMin: begin
        recip = MinRecip;
        dsr   = MinOdd;
      end
      DivWday: begin
        recip = WdayRecip;
        dsr   = WdayOdd;
      end
      default: begin
        recip = DayRecip;
        dsr   = DayOdd;
      end
    endcase
    prod = x_q * recip;
    back = est_q * dsr;
    diff = {1'b0, x_q} - back;
    part = diff[RedW:0];
    fits = part >= {1'b0, dsr};
    red  = fits ? RedW'(part - {1'b0, dsr}) : part[RedW-1:0];
  end

  always_comb begin
    mul_d  = go_i;
    fix_d  = mul_q;
    done_d = fix_q;
    op_d   = op_q;
    x_d    = x_q;
    low_d  = low_q;
    est_d  = est_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (go_i) begin
      op_d = op_i;
      unique case (op_i)
        DivDay: begin
          x_d   = dividend_i[DivW-1:7];
          low_d = dividend_i[6:0];
        end
        DivHour: begin
          x_d   = {12'd0, dividend_i[16:4]};
          low_d = {3'd0, dividend_i[3:0]};
        end
        DivMin: begin
          x_d   = {15'd0, dividend_i[11:2]};
          low_d = {5'd0, dividend_i[1:0]};
        end
        default: begin
          x_d   = {9'd0, dividend_i[15:0]};
          low_d = '0;
        end
      endcase
    end
    if (mul_q) begin
      est_d = prod[RecipSh +: DaysW];
    end
    if (fix_q) begin
      quo_d = fits ? est_q + 1'b1 : est_q;
      unique case (op_q)
        DivDay:  rem_d = {red, low_q};
        DivHour: rem_d = {5'd0, red[7:0], low_q[3:0]};
        DivMin:  rem_d = {11'd0, red[3:0], low_q[1:0]};
        default: rem_d = {14'd0, red[2:0]};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      op_q   <= DivDay;
    end else begin
      mul_q  <= mul_d;
      fix_q  <= fix_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    low_q <= low_d;
    est_q <= est_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

/* hw/rtl/epc_dp.sv */
module epc_dp import epc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] epoch_seconds_i,
  input  epc_cmd_t    cmd_i,
  output epc_status_t status_o,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [2:0]  weekday_o,
  output logic [7:0]  year_since_1900_o,
  output logic [8:0]  day_of_year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o
);

  logic [DivW-1:0]  dividend;
  logic             div_done;
  logic [DaysW-1:0] quo;
  logic [RemW-1:0]  rem;

  div_op_e          op_q;
  logic [DaysW-1:0] days_q;
  logic [5:0]       second_q, minute_q;
  logic [4:0]       hour_q;
  logic [2:0]       weekday_q;
  logic [7:0]       year_q;
  logic [8:0]       yday_q, work_q;
  logic [3:0]       mon_q;
  logic [4:0]       mday_q;

  logic       leap;
  logic [8:0] year_len;
  logic [8:0] mstart;
  logic       year_end;
  logic       mon_end;
  logic [8:0] mday_off;

  // The hour and minute divisions start from the remainder still held by the divider.
  always_comb begin
    dividend = epoch_seconds_i;
    unique case (cmd_i.div_op)
      DivDay: begin
        dividend = epoch_seconds_i;
      end
      DivHour: begin
        dividend = {{(DivW-RemW){1'b0}}, rem};
      end
      DivMin: begin
        dividend = {20'd0, rem[11:0]};
      end
      DivWday: begin
        dividend = {{(DivW-DaysW){1'b0}}, days_q + WdayOffset};
      end
      default: begin
        dividend = epoch_seconds_i;
      end
    endcase
  end

  epc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.div_go),
    .op_i       (cmd_i.div_op),
    .dividend_i (dividend),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  assign leap     = is_leap(year_q);
  assign year_len = leap ? DaysLeap : DaysCommon;
  assign year_end = days_q < {7'd0, year_len};
  assign mstart   = month_start(mon_q);
  assign mon_end  = (mon_q == 4'd0) || (mstart <= work_q);
  assign mday_off = work_q - mstart;

  assign status_o.div_done = div_done;
  assign status_o.year_end = year_end;
  assign status_o.mon_end  = mon_end;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      op_q <= cmd_i.div_op;
    end
    if (cmd_i.load) begin
      year_q <= YearBase;
    end
    if (cmd_i.div_take) begin
      case (op_q)
        DivDay: begin
          days_q <= quo;
        end
        DivHour: begin
          hour_q <= quo[4:0];
        end
        DivMin: begin
          minute_q <= quo[5:0];
          second_q <= rem[5:0];
        end
        default: begin
          weekday_q <= rem[2:0];
        end
      endcase
    end
    if (cmd_i.year_step && !year_end) begin
      days_q <= days_q - {7'd0, year_len};
      year_q <= year_q + 8'd1;
    end
    if (cmd_i.leap_fix) begin
      yday_q <= days_q[8:0];
      mon_q  <= MonthDec;
      if (leap && (days_q[8:0] > LastFebDay)) begin
        work_q <= days_q[8:0] - 9'd1;
        mday_q <= (days_q[8:0] == LeapDay) ? 5'd2 : 5'd1;
      end else begin
        work_q <= days_q[8:0];
        mday_q <= 5'd1;
      end
    end
    if (cmd_i.mon_step && !mon_end) begin
      mon_q <= mon_q - 4'd1;
    end
    if (cmd_i.finish) begin
      mday_q <= mday_q + mday_off[4:0];
    end
  end

  assign second_o          = second_q;
  assign minute_o          = minute_q;
  assign hour_o            = hour_q;
  assign weekday_o         = weekday_q;
  assign year_since_1900_o = year_q;
  assign day_of_year_o     = yday_q;
  assign month_o           = mon_q;
  assign day_of_month_o    = mday_q;

endmodule

/* hw/rtl/epc_ctrl.sv */
module epc_ctrl import epc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  epc_status_t status_i,
  output epc_cmd_t    cmd_o,
  output logic        busy_o,
  output logic        done_o
);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StDivDay  = 4'd1;
  localparam logic [3:0] StDivHour = 4'd2;
  localparam logic [3:0] StDivMin  = 4'd3;
  localparam logic [3:0] StDivWday = 4'd4;
  localparam logic [3:0] StYear    = 4'd5;
  localparam logic [3:0] StLeap    = 4'd6;
  localparam logic [3:0] StMonth   = 4'd7;
  localparam logic [3:0] StDone    = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_op = DivDay;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load   = 1'b1;
          cmd_o.div_go = 1'b1;
          cmd_o.div_op = DivDay;
          state_d      = StDivDay;
        end
      end
      StDivDay: begin
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          cmd_o.div_go   = 1'b1;
          cmd_o.div_op   = DivHour;
          state_d        = StDivHour;
        end
      end
      StDivHour: begin
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          cmd_o.div_go   = 1'b1;
          cmd_o.div_op   = DivMin;
          state_d        = StDivMin;
        end
      end
      StDivMin: begin
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          cmd_o.div_go   = 1'b1;
          cmd_o.div_op   = DivWday;
          state_d        = StDivWday;
        end
      end
      StDivWday: begin
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = StYear;
        end
      end
      StYear: begin
        cmd_o.year_step = 1'b1;
        if (status_i.year_end) begin
          state_d = StLeap;
        end
      end
      StLeap: begin
        cmd_o.leap_fix = 1'b1;
        state_d        = StMonth;
      end
      StMonth: begin
        cmd_o.mon_step = 1'b1;
        if (status_i.mon_end) begin
          cmd_o.finish = 1'b1;
          state_d      = StDone;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StDone);

endmodule

/* hw/rtl/epoch_seconds_to_calendar.sv */
// After an item is accepted, the result strobe follows the four divisions, the year steps, one per
// whole year past 1970 (0 to 136), the leap-day fix and the month table steps (0 to 11).
// Throughput: one item at a time; the next item is accepted the cycle after the strobe.
// Reset is asynchronous and active low; it returns the controller to idle with no strobe.
// Results are shown for one cycle only, as the receiver cannot stall.
module epoch_seconds_to_calendar import epc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds_i,
  output logic        done_o,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [2:0]  weekday_o,
  output logic [7:0]  year_since_1900_o,
  output logic [8:0]  day_of_year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o
);

  epc_cmd_t    cmd;
  epc_status_t status;

  epc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  epc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .epoch_seconds_i   (epoch_seconds_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .second_o          (second_o),
    .minute_o          (minute_o),
    .hour_o            (hour_o),
    .weekday_o         (weekday_o),
    .year_since_1900_o (year_since_1900_o),
    .day_of_year_o     (day_of_year_o),
    .month_o           (month_o),
    .day_of_month_o    (day_of_month_o)
  );

endmodule

/* hw/rtl/epc_chk.sv */
module epc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [31:0] epoch_seconds_i,
  input logic        done_o,
  input logic [5:0]  second_o,
  input logic [5:0]  minute_o,
  input logic [4:0]  hour_o,
  input logic [2:0]  weekday_o,
  input logic [7:0]  year_since_1900_o,
  input logic [8:0]  day_of_year_o,
  input logic [3:0]  month_o,
  input logic [4:0]  day_of_month_o
);

  // An accepted item keeps the block busy until its result has been shown.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after accepting an item");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (second_o < 6'd60) && (minute_o < 6'd60) && (hour_o < 5'd24)
               && (weekday_o < 3'd7))
    else $error("time of day or weekday out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_o < 4'd12) && (day_of_month_o != 5'd0)
               && (day_of_year_o < 9'd366 || day_of_year_o == 9'd365)
               && (year_since_1900_o >= 8'd70) && (year_since_1900_o <= 8'd206)
               && (epoch_seconds_i == epoch_seconds_i))
    else $error("calendar date out of range");

endmodule

bind epoch_seconds_to_calendar epc_chk u_chk (.*);

/* tb/testbench.sv */
module testbench;
  import epc_pkg::*;

  localparam int unsigned NumRandom  = 800;
  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned DrainWait  = 300;
  localparam int unsigned MaxDay     = 49710;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] year_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month;
    logic [4:0] day_of_month;
  } cal_t;

  class calendar_scoreboard;
    cal_t        expected_dates [$];
    int unsigned cum_days [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int unsigned n_noted;
    int unsigned n_checked;
    int unsigned n_bad;
    int unsigned n_leap_days;
    int unsigned min_year = 9999;
    int unsigned max_year;

    static function bit is_leap_year(int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function cal_t to_calendar(logic [31:0] secs);
      cal_t        r;
      int unsigned t;
      int unsigned tod;
      int unsigned days;
      int unsigned yr;
      int unsigned len;
      int unsigned wk;
      int unsigned mon;
      int unsigned mday;
      t    = secs;
      tod  = t % 86400;
      days = t / 86400;
      r.second  = 6'(tod % 60);
      r.minute  = 6'((tod / 60) % 60);
      r.hour    = 5'(tod / 3600);
      r.weekday = 3'((days + 4) % 7);
      yr  = 1970;
      len = is_leap_year(yr) ? 366 : 365;
      while (days >= len) begin
        days -= len;
        yr++;
        len = is_leap_year(yr) ? 366 : 365;
      end
      r.year_since_1900 = 8'(yr - 1900);
      r.day_of_year     = 9'(days);
      wk   = days;
      mday = 1;
      // Past 28 February in a leap year the table is searched one day earlier.
      if (is_leap_year(yr) && wk > 58) begin
        if (wk == 59) begin
          mday = 2;
        end
        wk--;
      end
      mon = 11;
      while (mon > 0 && cum_days[mon] > wk) begin
        mon--;
      end
      mday += wk - cum_days[mon];
      r.month        = 4'(mon);
      r.day_of_month = 5'(mday);
      return r;
    endfunction

    function void note(logic [31:0] secs);
      expected_dates.push_back(to_calendar(secs));
      n_noted++;
    endfunction

    function void check(cal_t got);
      cal_t exp;
      if (expected_dates.size() == 0) begin
        n_bad++;
        if (n_bad <= ReportMax) begin
          $display("Result with no item outstanding: %p", got);
        end
        return;
      end
      exp = expected_dates.pop_front();
      n_checked++;
      if (exp.month == 4'd1 && exp.day_of_month == 5'd29) begin
        n_leap_days++;
      end
      if (exp.year_since_1900 + 1900 < min_year) begin
        min_year = exp.year_since_1900 + 1900;
      end
      if (exp.year_since_1900 + 1900 > max_year) begin
        max_year = exp.year_since_1900 + 1900;
      end
      if (got.second !== exp.second || got.minute !== exp.minute ||
          got.hour !== exp.hour || got.weekday !== exp.weekday ||
          got.year_since_1900 !== exp.year_since_1900 ||
          got.day_of_year !== exp.day_of_year || got.month !== exp.month ||
          got.day_of_month !== exp.day_of_month) begin
        n_bad++;
        if (n_bad <= ReportMax) begin
          $display("Mismatch on result %0d", n_checked);
          $display("  expected: %p", exp);
          $display("  actual:   %p", got);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] epoch_seconds_i;
  logic        done_o;
  logic [5:0]  second_o;
  logic [5:0]  minute_o;
  logic [4:0]  hour_o;
  logic [2:0]  weekday_o;
  logic [7:0]  year_since_1900_o;
  logic [8:0]  day_of_year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_of_month_o;

  calendar_scoreboard sb = new();
  int unsigned        idle_cycles = 0;

  logic [31:0] corners [$] = '{
    32'd0, 32'd59, 32'd60, 32'd3600, 32'd86399, 32'd86400,
    32'd31535999, 32'd31536000, 32'd68169599, 32'd68169600,
    32'd68255999, 32'd68256000, 32'd94608000, 32'd94694399,
    32'd951782400, 32'd951868800, 32'd978307199, 32'd2147483647,
    32'd2147483648, 32'd4107542399, 32'd4107542400, 32'd4133894400,
    32'd4291747200, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
  };

  epoch_seconds_to_calendar dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .epoch_seconds_i   (epoch_seconds_i),
    .done_o            (done_o),
    .second_o          (second_o),
    .minute_o          (minute_o),
    .hour_o            (hour_o),
    .weekday_o         (weekday_o),
    .year_since_1900_o (year_since_1900_o),
    .day_of_year_o     (day_of_year_o),
    .month_o           (month_o),
    .day_of_month_o    (day_of_month_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The result is checked first; no item is accepted at the same edge, as busy is high then.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check({second_o, minute_o, hour_o, weekday_o, year_since_1900_o,
                  day_of_year_o, month_o, day_of_month_o});
      end
      if (start && !busy) begin
        sb.note(epoch_seconds_i);
      end
      if (done_o || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("Timed out after %0d cycles with nothing accepted", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  function automatic int unsigned year_first_day(int unsigned yr);
    int unsigned d;
    d = 0;
    for (int unsigned y = 1970; y < yr; y++) begin
      d += calendar_scoreboard::is_leap_year(y) ? 366 : 365;
    end
    return d;
  endfunction

  // Half uniform values, the rest clustered on midnights, leap days and year ends.
  function automatic logic [31:0] pick_epoch();
    int unsigned sel;
    int unsigned day;
    int unsigned tod;
    longint      total;
    sel = $urandom_range(3);
    if (sel < 2) begin
      return $urandom;
    end
    case ($urandom_range(2))
      0: tod = 0;
      1: tod = 86399;
      default: tod = $urandom_range(86399);
    endcase
    if (sel == 2) begin
      day = $urandom_range(MaxDay);
    end else begin
      day = year_first_day($urandom_range(2106, 1970));
      case ($urandom_range(5))
        0: day += 0;
        1: day += 58;
        2: day += 59;
        3: day += 60;
        4: day += 364;
        default: day += 365;
      endcase
    end
    total = longint'(day) * 86400 + tod;
    if (total > longint'(32'hFFFF_FFFF)) begin
      return $urandom;
    end
    return total[31:0];
  endfunction

  task automatic send_date(input logic [31:0] secs, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    epoch_seconds_i <= secs;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    start           = 1'b0;
    epoch_seconds_i = '0;
    rst_ni          = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corners[i]) begin
      send_date(corners[i], pick_gap());
    end
    for (int unsigned n = 0; n < NumRandom; n++) begin
      send_date(pick_epoch(), (n >= 300 && n < 400) ? 0 : pick_gap());
    end
    start <= 1'b0;

    while (sb.expected_dates.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Converted %0d items, %0d from corner dates and %0d random.",
             sb.n_noted, corners.size(), NumRandom);
    $display("Results spanned years %0d to %0d and included %0d leap days.",
             sb.min_year, sb.max_year, sb.n_leap_days);
    if (sb.n_bad == 0 && sb.expected_dates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.n_bad, sb.expected_dates.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
